@@ src/ffa_pkg.sv @@
// Shared types and constants for the first-fit allocator.
// Used by ffa_cell, first_fit_allocator, the checker and the testbench; no dependencies.
package ffa_pkg;
  localparam int MemUnits  = 128;
  localparam int TagBits   = 8;
  localparam int AddrBits  = $clog2(MemUnits);
  localparam int LenBits   = $clog2(MemUnits + 1);
  localparam logic [TagBits-1:0] TagMax = {TagBits{1'b1}};

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StBadAddr = 2'd2;
  localparam logic [1:0] StNoTag   = 2'd3;

  // reset pattern of the tag row
  function automatic logic [TagBits-1:0] preset_tag(input int u);
    logic [TagBits-1:0] t;
    t = '0;
    if (u >= 9 && u <= 15) t = TagBits'(1);
    else if (u >= 16 && u <= 22) t = TagBits'(2);
    else if (u >= 38 && u <= 45) t = TagBits'(3);
    return t;
  endfunction
endpackage

@@ src/ffa_cell.sv @@
// One unit of the tag row: holds its tag, rotates with the ring each step.
// Depends on ffa_pkg.
module ffa_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ffa_pkg::TagBits-1:0]     rst_tag,
  input  logic                            shift,
  input  logic [ffa_pkg::TagBits-1:0]     tag_in,
  output logic [ffa_pkg::TagBits-1:0]     tag
);
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= rst_tag;
    end else if (shift) begin
      tag <= tag_in;
    end
  end
endmodule

@@ src/first_fit_allocator.sv @@
// First-fit allocator over a row of tag cells that rotates as a ring, one unit
// past the head each cycle while scanning. A request is taken only while the
// engine is idle. Release and failed allocate requests run from one accept to
// the next through a start step, one full turn of the ring, and a step that
// hands the result to the output register. A successful allocation needs a
// second turn to write its tags. An allocate with the tags exhausted skips the
// scan and goes straight to the output step. The output register lets the next
// request run while a result waits. A second finished result holds the engine,
// and with it the input, until the register drains.
// Depends on ffa_pkg and ffa_cell.
module first_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [0] mode, [8:1] size, [15:9] address
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // [1:0] status, [8:2] block_start,
                                // [16:9] block_length, [24:17] owner_tag
);
  localparam int TB = ffa_pkg::TagBits;
  localparam int AB = ffa_pkg::AddrBits;
  localparam int LB = ffa_pkg::LenBits;
  localparam int N  = ffa_pkg::MemUnits;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_OUT = 3'b100
  } state_t;

  state_t state;
  logic [TB-1:0] tags [N];
  logic [TB-1:0] head_next;
  logic [TB-1:0] tag_counter, cur_tag;
  logic          mode;
  logic [7:0]    size;
  logic [AB-1:0] address;
  logic [LB-1:0] pos;           // unit index at the head of the ring
  logic [LB-1:0] run_len, done_len;
  logic [AB-1:0] run_start, res_start;
  logic          found, rel_on, scan_end, wr_pass;
  logic          fit_hit, wr_hit, rel_hit, out_load;
  logic [1:0]    res_status;
  logic [TB-1:0] res_tag;
  logic          shift;
  logic [AB-1:0] pos_a;

  assign shift = (state == S_SCAN);
  assign pos_a = pos[AB-1:0];
  assign scan_end = (pos == LB'(N - 1));

  // run at the head completes the request on this unit
  assign fit_hit = !wr_pass && !found && tags[0] == '0 && size != 8'd0 &&
                   (run_len + 1'b1 >= LB'(size));
  // second turn: tag the units of the chosen run
  assign wr_hit  = wr_pass && pos_a >= res_start && done_len < LB'(size);
  assign rel_hit = !rel_on && pos_a == address && tags[0] != '0 && done_len == '0;

  // head cell is unit pos; on shift it moves to the tail after update
  always_comb begin
    head_next = tags[0];
    if (!mode) begin
      if (wr_hit) head_next = cur_tag;
    end else if (rel_on && tags[0] == res_tag) begin
      head_next = '0;
    end else if (rel_hit) begin
      head_next = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffa_cell u_cell (
      .clk(clk), .rst(rst), .rst_tag(ffa_pkg::preset_tag(i)), .shift(shift),
      .tag_in((i == N - 1) ? head_next : tags[(i + 1) % N]), .tag(tags[i])
    );
  end

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, res_tag, done_len, res_start, res_status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tag_counter <= TB'(3);
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          mode <= s_tdata[0]; size <= s_tdata[8:1]; address <= s_tdata[15:9];
          pos <= '0; run_len <= '0; done_len <= '0; found <= 1'b0;
          rel_on <= 1'b0; wr_pass <= 1'b0; res_start <= '0; res_tag <= '0;
          if (!s_tdata[0] && tag_counter == ffa_pkg::TagMax) begin
            res_status <= ffa_pkg::StNoTag;
            state <= S_OUT;
          end else begin
            if (!s_tdata[0]) begin
              tag_counter <= tag_counter + 1'b1;
              cur_tag <= tag_counter + 1'b1;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pos <= scan_end ? '0 : pos + 1'b1;
          if (!mode) begin
            if (wr_pass) begin
              if (wr_hit) done_len <= done_len + 1'b1;
            end else if (!found) begin
              if (tags[0] == '0 && size != 8'd0) begin
                if (run_len == '0) run_start <= pos_a;
                run_len <= run_len + 1'b1;
                if (fit_hit) begin
                  found <= 1'b1;
                  res_start <= (run_len == '0) ? pos_a : run_start;
                end
              end else begin
                run_len <= '0;
              end
            end
          end else begin
            if (rel_on) begin
              if (tags[0] == res_tag) done_len <= done_len + 1'b1;
              else rel_on <= 1'b0;
            end else if (rel_hit) begin
              rel_on <= 1'b1; res_tag <= tags[0]; res_start <= pos_a;
              done_len <= LB'(1);
            end
          end
          if (scan_end) begin
            if (!mode) begin
              if (wr_pass) begin
                res_status <= ffa_pkg::StOk; res_tag <= cur_tag;
                state <= S_OUT;
              end else if (found || fit_hit) begin
                // run lies behind the head: tag it on the next turn
                wr_pass <= 1'b1;
              end else begin
                res_status <= ffa_pkg::StNoFit;
                state <= S_OUT;
              end
            end else if (done_len != '0 || rel_hit) begin
              res_status <= ffa_pkg::StOk;
              if (tag_counter != '0) tag_counter <= tag_counter - 1'b1;
              state <= S_OUT;
            end else begin
              res_status <= ffa_pkg::StBadAddr;
              state <= S_OUT;
            end
          end
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ffa_pkg::StOk) |-> (m_tdata[24:2] == '0))
    else $error("failed request carries a block");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ffa_pkg::StOk) |->
      (m_tdata[16:9] != 8'd0 &&
       ({2'b00, m_tdata[8:2]} + {1'b0, m_tdata[16:9]}) <= 9'(N)))
    else $error("block outside memory");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
endmodule

@@ verif/first_fit_allocator_chk.sv @@
// Checker for first_fit_allocator: watches both stream channels, predicts each
// result from its own tag row and counter, and counts mismatches.
// Depends on ffa_pkg.
`timescale 1ns / 100ps
module first_fit_allocator_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] len;
    logic [6:0] start;
    logic [1:0] status;
  } alloc_result_t;

  logic [ffa_pkg::TagBits-1:0] tag_row [ffa_pkg::MemUnits];
  logic [ffa_pkg::TagBits-1:0] tag_count;
  alloc_result_t               want_q[$];

  assign pending = want_q.size();

  function automatic alloc_result_t predict_request(input logic [15:0] req);
    alloc_result_t r;
    int run_start, run_len;
    logic found;
    logic [ffa_pkg::TagBits-1:0] t;
    int size, addr;
    r = '0;
    size = int'(req[8:1]);
    addr = int'(req[15:9]);
    run_start = 0;
    run_len = 0;
    found = 1'b0;
    if (!req[0]) begin
      if (tag_count == ffa_pkg::TagMax) begin
        r.status = ffa_pkg::StNoTag;
        return r;
      end
      tag_count = tag_count + 1'b1;
      r.status = ffa_pkg::StNoFit;
      if (size == 0 || size > ffa_pkg::MemUnits) return r;
      for (int u = 0; u < ffa_pkg::MemUnits && !found; u++) begin
        if (tag_row[u] == '0) begin
          if (run_len == 0) run_start = u;
          run_len++;
          if (run_len >= size) found = 1'b1;
        end else begin
          run_len = 0;
        end
      end
      if (!found) return r;
      for (int k = 0; k < size; k++) tag_row[run_start+k] = tag_count;
      r.status = ffa_pkg::StOk;
      r.start  = 7'(run_start);
      r.len    = 8'(size);
      r.tag    = tag_count;
    end else begin
      if (tag_row[addr] == '0) begin
        r.status = ffa_pkg::StBadAddr;
        return r;
      end
      t = tag_row[addr];
      run_len = 0;
      for (int u = addr; u < ffa_pkg::MemUnits && tag_row[u] == t; u++) begin
        tag_row[u] = '0;
        run_len++;
      end
      if (tag_count != '0) tag_count = tag_count - 1'b1;
      r.status = ffa_pkg::StOk;
      r.start  = 7'(addr);
      r.len    = 8'(run_len);
      r.tag    = t;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst) begin
      for (int u = 0; u < ffa_pkg::MemUnits; u++) tag_row[u] = ffa_pkg::preset_tag(u);
      tag_count = ffa_pkg::TagBits'(3);
      want_q.delete();
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) want_q.push_back(predict_request(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[24:0];
        if (want_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: exp st %0d st %0d len %0d tag %0d, got %0d %0d %0d %0d",
                       want.status, want.start, want.len, want.tag,
                       got.status, got.start, got.len, got.tag);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/first_fit_allocator_tb.sv @@
// Testbench top for first_fit_allocator: drives allocate and release requests
// with bursty gaps and output stalls; the checker module does the predicting.
// Depends on ffa_pkg, first_fit_allocator and first_fit_allocator_chk.
`timescale 1ns / 100ps
module first_fit_allocator_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic        hold_off = 1'b0;
  logic [6:0]  live_addr [$];

  first_fit_allocator u_top (.*);

  first_fit_allocator_chk u_chk (.*);

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("first_fit_allocator_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, occasional long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else case (cycles % 3000 < 1500)
      1'b1: m_tready <= 1'b1;
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // leaves tvalid high; callers drop it before any gap
  task automatic send_request(input logic is_release, input logic [7:0] size,
                              input logic [6:0] addr);
    s_tvalid <= 1'b1;
    s_tdata  <= {addr, size, is_release};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_request(1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(1, 24)),
                   7'($urandom));
    else if (pick < 85 && live_addr.size() > 0)
      send_request(1'b1, 8'($urandom), live_addr[$urandom_range(0, live_addr.size() - 1)]);
    else
      send_request(1'b1, 8'($urandom), 7'($urandom));
  endtask

  // track block starts seen so releases mostly hit real blocks
  always @(posedge clk) begin
    if (m_tvalid && m_tready && m_tdata[1:0] == ffa_pkg::StOk &&
        m_tdata[2+ffa_pkg::AddrBits-1:2] !== 'x)
      live_addr.push_back(m_tdata[8:2]);
    if (live_addr.size() > 40) void'(live_addr.pop_front());
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: preset blocks, extremes, zero and oversize, bad addresses
    send_request(1'b1, 8'd0, 7'd9);
    send_request(1'b1, 8'd0, 7'd9);
    send_request(1'b1, 8'd0, 7'd127);
    send_request(1'b0, 8'd0, 7'd0);
    send_request(1'b0, 8'd129, 7'd0);
    send_request(1'b0, 8'd255, 7'd0);
    send_request(1'b0, 8'd1, 7'd0);
    send_request(1'b0, 8'd1, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd1);
    send_request(1'b0, 8'd8, 7'd0);
    send_request(1'b0, 8'd9, 7'd0);
    send_request(1'b1, 8'd0, 7'd16);
    send_request(1'b1, 8'd0, 7'd38);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd9);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b0, 8'd128, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    send_request(1'b1, 8'd0, 7'd0);
    // counter up to its ceiling: many no-fit allocations
    send_request(1'b0, 8'd128, 7'd0);
    for (int i = 0; i < 260; i++) send_request(1'b0, 8'd200, 7'($urandom));
    s_tvalid <= 1'b0;
    // pause until drained
    while (pending != 0) @(posedge clk);
    // long receiver hold-off while requests keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) random_request();
        s_tvalid <= 1'b0;
      end
    join
    // release and allocate a mix
    for (int i = 0; i < 130; i++) send_request(1'b1, 8'($urandom), 7'($urandom));
    for (int b = 0; b < 1150; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) random_request();
      b += burst;
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 300)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("first_fit_allocator_tb: done, clean");
    else $display("first_fit_allocator_tb: done, errors");
    $finish;
  end
endmodule

@@ sim.f @@
src/ffa_pkg.sv
src/ffa_cell.sv
src/first_fit_allocator.sv
verif/first_fit_allocator_chk.sv
verif/first_fit_allocator_tb.sv
